### src/assert_macros.svh
// Assertion macros shared by the RTL of the cipher block.
// Needs no other file; in synthesis every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(name, clk, rst_n, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// Implication whose consequence is checked at the following rising edge.
`define ASSERT_NEXT(name, clk, rst_n, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(name, clk, rst_n, cond, prop)
`define ASSERT_NEXT(name, clk, rst_n, cond, prop)
`endif
`endif

### src/aes_pkg.sv
// Constants, S-box tables and round functions of the AES-128 block.
// Depends on nothing; imported by aes128_block_cipher.
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CntW = 4;

  typedef logic [127:0] blk_t;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    REG_KEY_HIGH = 8'd0,
    REG_KEY_LOW  = 8'd1
  } reg_idx_e;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  // Multiply by x in GF(2^8) modulo 0x11B.
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // Byte i of the block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input blk_t s, input int unsigned i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic blk_t byte_subst(input blk_t s, input logic inv);
    blk_t o;
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : FWD_SBOX[get_byte(s, i)];
    end
    return o;
  endfunction

  function automatic blk_t row_rotate(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (r + 4 * c) -: 8] = get_byte(s, r + 4 * ((c + r) % 4));
      end
    end
    return o;
  endfunction

  function automatic blk_t inv_row_rotate(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = get_byte(s, r + 4 * c);
      end
    end
    return o;
  endfunction

  // Forward column mix with coefficients 2, 3, 1, 1.
  function automatic blk_t col_mix(input blk_t s);
    blk_t o;
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = get_byte(s, 4 * c + j);
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * c + r) -: 8] = xtime(a[r]) ^ xtime(a[(r + 1) % 4]) ^
            a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
      end
    end
    return o;
  endfunction

  // Inverse column mix with coefficients 14, 11, 13, 9.
  function automatic blk_t inv_col_mix(input blk_t s);
    blk_t o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = get_byte(s, 4 * c + j);
        x2[j] = xtime(a[j]);
        x4[j] = xtime(x2[j]);
        x8[j] = xtime(x4[j]);
      end
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * c + r) -: 8] =
            (x8[r] ^ x4[r] ^ x2[r]) ^
            (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4]) ^
            (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4]) ^
            (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
      end
    end
    return o;
  endfunction

  // Next round key from the previous one and the round constant.
  function automatic blk_t key_next(input blk_t k, input logic [7:0] rcon);
    logic [31:0] w3r;
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    w3r = {k[23:0], k[31:24]};
    t = {FWD_SBOX[w3r[31:24]] ^ rcon, FWD_SBOX[w3r[23:16]],
         FWD_SBOX[w3r[15:8]], FWD_SBOX[w3r[7:0]]};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage
`default_nettype wire

### src/aes128_block_cipher.sv
// AES-128 block cipher: one 16-byte block per word, encrypt or decrypt.
// Slave stream in (tuser = opcode), master stream out, key write channel.
// The unrolled round pipeline has one stage that adds the first round
// key and ten stages that each hold one full round.
// One block is accepted per cycle while the output is not stalled and no
// key expansion runs; opcodes may alternate freely. Each stage moves
// forward when the next one is empty or moving, so a stalled output fills
// the pipeline before s_axis_tready drops, and bubbles are squeezed out.
// Nothing is lost or repeated under stalls. The key is written with
// cfg_valid_i/cfg_ready_o, index 0 for key bytes 0 to 7 and index 1 for
// bytes 8 to 15; other indexes are ignored. Every write to index 0 or 1,
// and reset, starts a key expansion, one round key a cycle; input and key writes wait until it is done.
// A key write also waits until the pipeline is empty.
// Reset clears the key to zero and expands the all-zero key.
`default_nettype none
`include "assert_macros.svh"
module aes128_block_cipher
  import aes_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // data_high [63:0], data_low [127:64]
  input  wire logic [0:0]   s_axis_tuser,  // opcode [0]
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output      logic [127:0] m_axis_tdata,  // result_high [63:0], result_low [127:64]
  input  wire logic         cfg_valid_i,
  output      logic         cfg_ready_o,
  input  wire logic [7:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);

  // Key registers and key expansion sequencer.
  logic [63:0]     key_high_q, key_low_q;
  blk_t            rk_q [NumRounds + 1];
  blk_t            rk_work_q;
  logic [7:0]      rcon_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            cfg_fire;

  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      busy_q     <= 1'b1;
      cnt_q      <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        REG_KEY_HIGH: begin
          key_high_q <= cfg_data_i;
          busy_q     <= 1'b1;
          cnt_q      <= '0;
        end
        REG_KEY_LOW: begin
          key_low_q <= cfg_data_i;
          busy_q    <= 1'b1;
          cnt_q     <= '0;
        end
        default: begin
        end
      endcase
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(NumRounds)) busy_q <= 1'b0;
    end
  end

  // Round key storage, one key written per expansion cycle.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (cnt_q == '0) begin
        rk_q[0]   <= {key_high_q, key_low_q};
        rk_work_q <= {key_high_q, key_low_q};
        rcon_q    <= 8'h01;
      end else begin
        rk_q[cnt_q] <= key_next(rk_work_q, rcon_q);
        rk_work_q   <= key_next(rk_work_q, rcon_q);
        rcon_q      <= xtime(rcon_q);
      end
    end
  end

  // Round pipeline: stage 0 adds the first key, stages 1 to 10 are rounds.
  blk_t st_q    [NumRounds + 1];
  logic op_q    [NumRounds + 1];
  logic vld_q   [NumRounds + 1];
  logic rdy     [NumRounds + 1];
  blk_t rnd_out [NumRounds];
  blk_t in_blk;
  logic pipe_busy;

  assign rdy[NumRounds] = !vld_q[NumRounds] || m_axis_tready;
  for (genvar k = 0; k < NumRounds; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k + 1];
  end

  // Key writes wait until no block is in flight.
  always_comb begin
    pipe_busy = 1'b0;
    for (int i = 0; i <= NumRounds; i++) pipe_busy = pipe_busy | vld_q[i];
  end

  assign cfg_ready_o   = !busy_q && !pipe_busy;
  assign s_axis_tready = rdy[0] && !busy_q;
  assign in_blk        = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  for (genvar k = 1; k <= NumRounds; k++) begin : g_round
    blk_t enc_sr, dec_sb, enc_out, dec_out;

    // Encrypt: substitute, shift, mix (not in the last round), add key k.
    // Decrypt: inverse shift, inverse substitute, add key 10-k, inverse mix (not in the last round).
    always_comb begin
      enc_sr = row_rotate(byte_subst(st_q[k - 1], 1'b0));
      dec_sb = byte_subst(inv_row_rotate(st_q[k - 1]), 1'b1) ^ rk_q[NumRounds - k];
      if (k == NumRounds) begin
        enc_out = enc_sr ^ rk_q[k];
        dec_out = dec_sb;
      end else begin
        enc_out = col_mix(enc_sr) ^ rk_q[k];
        dec_out = inv_col_mix(dec_sb);
      end
    end

    assign rnd_out[k - 1] = op_q[k - 1] ? dec_out : enc_out;
  end

  // Valid bits of all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumRounds; i++) vld_q[i] <= 1'b0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid && s_axis_tready;
      for (int i = 1; i <= NumRounds; i++) begin
        if (rdy[i]) vld_q[i] <= vld_q[i - 1];
      end
    end
  end

  // Block and opcode registers of all stages.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      op_q[0] <= s_axis_tuser[0];
      st_q[0] <= in_blk ^ (s_axis_tuser[0] ? rk_q[NumRounds] : rk_q[0]);
    end
    for (int i = 1; i <= NumRounds; i++) begin
      if (rdy[i]) begin
        op_q[i] <= op_q[i - 1];
        st_q[i] <= rnd_out[i - 1];
      end
    end
  end

  // Output word from the last stage.
  assign m_axis_tvalid = vld_q[NumRounds];
  assign m_axis_tdata  = {st_q[NumRounds][63:0], st_q[NumRounds][127:64]};

  // Checks on the key sequencer and the pipeline.
  `ASSERT_IMPLY(a_no_input_while_expanding, clk_i, rst_ni, busy_q, !s_axis_tready)
  `ASSERT_NEXT(a_key_write_starts_expansion, clk_i, rst_ni,
      cfg_fire && (cfg_index_i == REG_KEY_HIGH || cfg_index_i == REG_KEY_LOW),
      busy_q && cnt_q == '0)
  `ASSERT_NEXT(a_expansion_ends, clk_i, rst_ni,
      busy_q && !cfg_fire && cnt_q == CntW'(NumRounds), !busy_q)
  `ASSERT_NEXT(a_stalled_output_holds, clk_i, rst_ni,
      m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(st_q[NumRounds]))

endmodule
`default_nettype wire
